@@ rtl/bfdh_pkg.sv @@
// shared types, constants and codes of the double-hash bloom filter
`timescale 1ns / 1ps
`default_nettype none
package bfdh_pkg;

    // store geometry
    localparam int STORE_BITS = 65536;
    localparam int IDX_W      = 16;
    localparam int ROW_W      = 64;
    localparam int BIT_W      = 6;
    localparam int ROW_AW     = IDX_W - BIT_W;

    // register widths and limits
    localparam int SIZE_W     = 17;
    localparam int NH_W       = 5;
    localparam int HASH_W     = 64;
    localparam int DIV_CNT_W  = 6;

    localparam logic [SIZE_W-1:0] SIZE_MIN   = 17'd8;
    localparam logic [SIZE_W-1:0] SIZE_MAX   = 17'd65536;
    localparam logic [NH_W-1:0]   NH_MIN     = 5'd1;
    localparam logic [NH_W-1:0]   NH_MAX     = 5'd16;
    localparam logic [NH_W-1:0]   NH_RESET   = 5'd4;
    localparam logic [HASH_W-1:0] DJB_START  = 64'd5381;

    // request and result kinds
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_QUERY  = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_FILTER_SIZE = 2'd0;
    localparam logic [1:0] CFG_NUM_HASHES  = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PINIT,
        ST_PRB_RD,
        ST_PRB_WR,
        ST_CLR,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic div_step;
        logic probe_init;
        logic mem_rd;
        logic probe_wr;
        logic clr_init;
        logic clr_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic probe_last;
        logic clr_last;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

@@ rtl/bfdh_ctrl.sv @@
// controller state machine of the bloom filter
`timescale 1ns / 1ps
`default_nettype none
module bfdh_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_last,
    input  wire logic [1:0]       in_req,
    output logic                  in_ready,
    input  wire bfdh_pkg::status_t sts,
    output bfdh_pkg::cmd_t        cmd
);

    bfdh_pkg::state_t state_reg, state_next;
    logic emit_reg, emit_next;

    // state registers, reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bfdh_pkg::ST_CLR;
            emit_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            emit_reg  <= emit_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        emit_next  = emit_reg;
        case (state_reg)
            bfdh_pkg::ST_IDLE:
            begin
                if (in_valid && in_last)
                begin
                    if (in_req == bfdh_pkg::REQ_CLEAR)
                    begin
                        state_next = bfdh_pkg::ST_CLR;
                        emit_next  = 1'b1;
                    end
                    else if (in_req == bfdh_pkg::REQ_INSERT || in_req == bfdh_pkg::REQ_QUERY)
                    begin
                        state_next = bfdh_pkg::ST_DIV;
                    end
                end
            end
            bfdh_pkg::ST_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = bfdh_pkg::ST_PINIT;
                end
            end
            bfdh_pkg::ST_PINIT:  state_next = bfdh_pkg::ST_PRB_RD;
            bfdh_pkg::ST_PRB_RD: state_next = bfdh_pkg::ST_PRB_WR;
            bfdh_pkg::ST_PRB_WR:
            begin
                state_next = sts.probe_last ? bfdh_pkg::ST_OUT : bfdh_pkg::ST_PRB_RD;
            end
            bfdh_pkg::ST_CLR:
            begin
                if (sts.clr_last)
                begin
                    state_next = emit_reg ? bfdh_pkg::ST_OUT : bfdh_pkg::ST_IDLE;
                end
            end
            bfdh_pkg::ST_OUT:
            begin
                if (sts.out_free)
                begin
                    state_next = bfdh_pkg::ST_IDLE;
                end
            end
            default: state_next = bfdh_pkg::ST_IDLE;
        endcase
    end

    // command outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            bfdh_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.accept    = in_valid;
                cmd.div_start = in_valid && in_last &&
                                (in_req == bfdh_pkg::REQ_INSERT || in_req == bfdh_pkg::REQ_QUERY);
                cmd.clr_init  = in_valid && in_last && (in_req == bfdh_pkg::REQ_CLEAR);
            end
            bfdh_pkg::ST_DIV:    cmd.div_step   = 1'b1;
            bfdh_pkg::ST_PINIT:  cmd.probe_init = 1'b1;
            bfdh_pkg::ST_PRB_RD: cmd.mem_rd     = 1'b1;
            bfdh_pkg::ST_PRB_WR: cmd.probe_wr   = 1'b1;
            bfdh_pkg::ST_CLR:    cmd.clr_step   = 1'b1;
            bfdh_pkg::ST_OUT:    cmd.out_load   = sts.out_free;
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/bfdh_datapath.sv @@
// hashes, remainder unit, probe walk, bit store and output register
`timescale 1ns / 1ps
`default_nettype none
module bfdh_datapath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire bfdh_pkg::cmd_t        cmd,
    output bfdh_pkg::status_t          sts,
    input  wire logic [1:0]            in_req,
    input  wire logic [7:0]            in_byte,
    input  wire logic                  in_byte_valid,
    input  wire logic                  in_last,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_idx,
    input  wire logic [bfdh_pkg::SIZE_W-1:0] cfg_val,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [1:0]                 out_kind,
    output logic                       out_maybe
);

    localparam int SW = bfdh_pkg::SIZE_W;
    localparam int HW = bfdh_pkg::HASH_W;

    logic [SW-1:0] size_reg;
    logic [bfdh_pkg::NH_W-1:0] nh_reg;
    logic [HW-1:0] djb_reg, sdbm_reg, djb_fold, sdbm_fold, djb_next, sdbm_next, c_ext;
    logic [HW-1:0] da_reg, db_reg;
    logic [SW-1:0] ra_reg, rb_reg, ra_next, rb_next;
    logic [SW:0]   ta, tb;
    logic [bfdh_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [1:0]    req_reg;
    logic [SW-1:0] idx_reg, idx_next;
    logic [SW:0]   idx_sum;
    logic [bfdh_pkg::NH_W-1:0] pcnt_reg;
    logic          all_set_reg;
    logic [bfdh_pkg::ROW_AW-1:0] clr_cnt_reg;
    logic [bfdh_pkg::ROW_W-1:0]  mem [2**bfdh_pkg::ROW_AW];
    logic [bfdh_pkg::ROW_W-1:0]  rd_data_reg, wr_data;
    logic [bfdh_pkg::ROW_AW-1:0] wr_addr, rd_addr;
    logic          mem_we, cur_bit;
    logic          out_valid_reg;
    logic [1:0]    out_kind_reg;
    logic          out_maybe_reg;

    // configuration writes, saturated to the legal range
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= bfdh_pkg::SIZE_MAX;
            nh_reg   <= bfdh_pkg::NH_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_idx == bfdh_pkg::CFG_FILTER_SIZE)
            begin
                if (cfg_val < bfdh_pkg::SIZE_MIN)
                    size_reg <= bfdh_pkg::SIZE_MIN;
                else if (cfg_val > bfdh_pkg::SIZE_MAX)
                    size_reg <= bfdh_pkg::SIZE_MAX;
                else
                    size_reg <= cfg_val;
            end
            else if (cfg_idx == bfdh_pkg::CFG_NUM_HASHES)
            begin
                if (cfg_val[bfdh_pkg::NH_W-1:0] < bfdh_pkg::NH_MIN)
                    nh_reg <= bfdh_pkg::NH_MIN;
                else if (cfg_val[bfdh_pkg::NH_W-1:0] > bfdh_pkg::NH_MAX)
                    nh_reg <= bfdh_pkg::NH_MAX;
                else
                    nh_reg <= cfg_val[bfdh_pkg::NH_W-1:0];
            end
        end
    end

    // byte fold: h*33 + c and h*65599 + c as shifts and adds
    always_comb
    begin
        c_ext     = {{(HW-8){in_byte[7]}}, in_byte};
        djb_fold  = (djb_reg << 5) + djb_reg + c_ext;
        sdbm_fold = (sdbm_reg << 16) + (sdbm_reg << 6) - sdbm_reg + c_ext;
        djb_next  = in_byte_valid ? djb_fold : djb_reg;
        sdbm_next = in_byte_valid ? sdbm_fold : sdbm_reg;
    end

    // running hashes, back to start after each last transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            djb_reg  <= bfdh_pkg::DJB_START;
            sdbm_reg <= '0;
        end
        else if (cmd.accept)
        begin
            if (in_last)
            begin
                djb_reg  <= bfdh_pkg::DJB_START;
                sdbm_reg <= '0;
            end
            else
            begin
                djb_reg  <= djb_next;
                sdbm_reg <= sdbm_next;
            end
        end
    end

    // restoring remainder step, one dividend bit per cycle for both hashes
    always_comb
    begin
        ta = {ra_reg, da_reg[HW-1]};
        tb = {rb_reg, db_reg[HW-1]};
        ra_next = (ta >= {1'b0, size_reg}) ? SW'(ta - {1'b0, size_reg}) : ta[SW-1:0];
        rb_next = (tb >= {1'b0, size_reg}) ? SW'(tb - {1'b0, size_reg}) : tb[SW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            da_reg  <= djb_next;
            db_reg  <= sdbm_next;
            ra_reg  <= '0;
            rb_reg  <= '0;
            req_reg <= in_req;
        end
        else if (cmd.div_step)
        begin
            da_reg <= da_reg << 1;
            db_reg <= db_reg << 1;
            ra_reg <= ra_next;
            rb_reg <= rb_next;
        end
        else if (cmd.clr_init)
        begin
            req_reg <= bfdh_pkg::REQ_CLEAR;
        end
    end

    // probe walk: next index is idx + b, folded once below size
    always_comb
    begin
        idx_sum  = {1'b0, idx_reg} + {1'b0, rb_reg};
        idx_next = (idx_sum >= {1'b0, size_reg}) ? SW'(idx_sum - {1'b0, size_reg})
                                                 : idx_sum[SW-1:0];
        cur_bit  = rd_data_reg[idx_reg[bfdh_pkg::BIT_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcnt_reg <= '0;
        end
        else if (cmd.probe_init)
        begin
            pcnt_reg <= '0;
        end
        else if (cmd.probe_wr)
        begin
            pcnt_reg <= pcnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.probe_init)
        begin
            idx_reg     <= ra_reg;
            all_set_reg <= 1'b1;
        end
        else if (cmd.probe_wr)
        begin
            idx_reg     <= idx_next;
            all_set_reg <= all_set_reg & cur_bit;
        end
    end

    // clearing sweep counter, one row a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_init)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // status towards the controller
    always_comb
    begin
        sts.div_last   = (div_cnt_reg == {bfdh_pkg::DIV_CNT_W{1'b1}});
        sts.probe_last = (pcnt_reg == nh_reg - 1'b1);
        sts.clr_last   = (clr_cnt_reg == {bfdh_pkg::ROW_AW{1'b1}});
        sts.out_free   = !out_valid_reg || out_ready;
    end

    // bit store port selection
    always_comb
    begin
        rd_addr = idx_reg[bfdh_pkg::IDX_W-1:bfdh_pkg::BIT_W];
        if (cmd.clr_step)
        begin
            mem_we  = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end
        else
        begin
            mem_we  = cmd.probe_wr && (req_reg == bfdh_pkg::REQ_INSERT);
            wr_addr = idx_reg[bfdh_pkg::IDX_W-1:bfdh_pkg::BIT_W];
            wr_data = rd_data_reg |
                      (bfdh_pkg::ROW_W'(1) << idx_reg[bfdh_pkg::BIT_W-1:0]);
        end
    end

    // bit store rows, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_kind_reg  <= req_reg;
            out_maybe_reg <= (req_reg == bfdh_pkg::REQ_QUERY) ? all_set_reg : 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_maybe = out_maybe_reg;

endmodule
`default_nettype wire

@@ rtl/bloom_filter_double_hash.sv @@
// top level of the double-hash bloom filter
//
// channel | dir | handshake                   | payload
// s_*     | in  | s_tvalid / s_tready         | s_tdata key byte, s_tuser kind+flag, s_tlast
// m_*     | out | m_tvalid / m_tready         | m_tdata answer bit, m_tuser done kind
// cfg_*   | in  | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// a key byte that is not the last is taken while idle and leaves the controller idle
// insert or query end: 64 remainder steps, probe set-up, a read and write per probe, result
// clear end: all 1024 rows are cleared, then the result is loaded
// after reset all 1024 rows of the store are cleared before the first transfer
// a result pending in the output register holds back key bytes only while another waits
`timescale 1ns / 1ps
`default_nettype none
module bloom_filter_double_hash (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] key_byte
    input  wire logic [2:0]  s_tuser,   // [1:0] req_type, [2] byte_valid
    input  wire logic        s_tlast,   // end_of_key
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [0] maybe_present, [7:1] zero
    output logic [1:0]       m_tuser,   // [1:0] done_kind
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [16:0] cfg_data
);

    bfdh_pkg::cmd_t    cmd;
    bfdh_pkg::status_t sts;
    logic              maybe;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {7'b0, maybe};

    // controller
    bfdh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .in_req   (s_tuser[1:0]),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    bfdh_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .in_req        (s_tuser[1:0]),
        .in_byte       (s_tdata),
        .in_byte_valid (s_tuser[2]),
        .in_last       (s_tlast),
        .cfg_we        (cfg_valid),
        .cfg_idx       (cfg_index),
        .cfg_val       (cfg_data),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_kind      (m_tuser),
        .out_maybe     (maybe)
    );

endmodule
`default_nettype wire

@@ test/testbench.sv @@
// self-checking testbench of the double-hash bloom filter
`timescale 1ns / 1ps
module testbench;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE      = 1200;   // longer than a clear pass
    localparam int LONG_HOLD   = 3000;
    localparam int ITEM_GOAL   = 1650;
    localparam logic [1:0] REQ_NONE   = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] req;
        logic [7:0] kb;
        logic       bv;
        logic       last;
    } key_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       hit;
    } answer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;    // [7:0] key_byte
    logic [2:0]  s_tuser = '0;    // [1:0] req_type, [2] byte_valid
    logic        s_tlast = 1'b0;  // end_of_key
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [0] maybe_present, [7:1] zero
    logic [1:0]  m_tuser;         // [1:0] done_kind
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [16:0] cfg_data = '0;

    bloom_filter_double_hash dut (.*);

    always #5 clk = ~clk;

    // predictor state
    logic [63:0]        djb_acc = 64'd5381;
    logic [63:0]        sdbm_acc = '0;
    logic [63:0]        bits_in_use = 64'd65536;
    int                 probe_count = 4;
    logic [65535:0]     filter_bits = '0;

    key_item_t pending_items[$];
    answer_t   answers_due[$];
    int        items_pushed = 0;
    int        items_taken = 0;
    bit        failed = 0;
    bit        taken = 0;
    bit        burst = 0;
    bit        stall_go = 0;
    int        stall_cnt = 0;
    int        tx_gap = 0;
    int        rx_gap = 0;
    int        cycles = 0;

    logic [63:0] key_pool[16];
    int          key_len[16];

    task automatic fold_item(input key_item_t it);
        logic [63:0] c, a, b, idx;
        bit all_set;
        answer_t ans;
        if (it.bv)
        begin
            c = {{56{it.kb[7]}}, it.kb};
            djb_acc  = djb_acc * 64'd33 + c;
            sdbm_acc = sdbm_acc * 64'd65599 + c;
        end
        if (!it.last)
            return;
        a = djb_acc % bits_in_use;
        b = sdbm_acc % bits_in_use;
        djb_acc  = 64'd5381;
        sdbm_acc = '0;
        if (it.req == REQ_NONE)
            return;
        all_set = 1;
        if (it.req == bfdh_pkg::REQ_CLEAR)
            filter_bits = '0;
        else
        begin
            for (int i = 0; i < probe_count; i++)
            begin
                idx = (a + i * b) % bits_in_use;
                if (it.req == bfdh_pkg::REQ_INSERT)
                    filter_bits[idx[15:0]] = 1'b1;
                else if (!filter_bits[idx[15:0]])
                    all_set = 0;
            end
        end
        ans.kind = it.req;
        ans.hit  = (it.req == bfdh_pkg::REQ_QUERY) ? all_set : 1'b0;
        answers_due = {answers_due, ans};
    endtask

    function automatic key_item_t mk(input logic [1:0] req, input logic [7:0] kb,
                                     input logic bv, input logic last);
        key_item_t it;
        it.req = req; it.kb = kb; it.bv = bv; it.last = last;
        return it;
    endfunction

    task automatic push(input key_item_t it);
        pending_items = {pending_items, it};
        items_pushed++;
    endtask

    // one key with optional noise items, last byte on the end item or not
    task automatic push_key(input logic [63:0] kbytes, input int klen, input logic [1:0] req);
        bit on_end;
        on_end = (klen > 0) && $urandom_range(0, 1);
        for (int i = 0; i < klen; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                push(mk(2'($urandom_range(0, 3)), 8'($urandom), 1'b0, 1'b0));
            if (on_end && i == klen - 1)
                push(mk(req, kbytes[i*8 +: 8], 1'b1, 1'b1));
            else
                push(mk(2'($urandom_range(0, 3)), kbytes[i*8 +: 8], 1'b1, 1'b0));
        end
        if (!on_end)
            push(mk(req, 8'($urandom), 1'b0, 1'b1));
    endtask

    // configuration write while the filter is idle
    task automatic write_reg(input logic [1:0] index, input logic [16:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (index == bfdh_pkg::CFG_FILTER_SIZE)
            bits_in_use = (value < 17'd8) ? 64'd8 : (value > 17'd65536) ? 64'd65536 : value;
        else if (index == bfdh_pkg::CFG_NUM_HASHES)
            probe_count = (value[4:0] < 5'd1) ? 1 : (value[4:0] > 5'd16) ? 16 : value[4:0];
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain();
        wait (items_taken == items_pushed && answers_due.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic random_phase(input int n);
        int stop, r, slot;
        stop = items_pushed + n;
        while (items_pushed < stop)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                push_key(64'($urandom), $urandom_range(0, 2), bfdh_pkg::REQ_CLEAR);
            else if (r < 6)
                push_key({$urandom, $urandom}, $urandom_range(0, 8), REQ_NONE);
            else if (r < 60)
            begin
                slot = $urandom_range(0, 15);
                push_key(key_pool[slot], key_len[slot], 2'($urandom_range(0, 1)));
            end
            else
            begin
                slot = $urandom_range(0, 15);
                key_pool[slot] = {$urandom, $urandom};
                key_len[slot]  = $urandom_range(0, 8);
                push_key(key_pool[slot], key_len[slot], 2'($urandom_range(0, 1)));
            end
        end
        drain();
    endtask

    // sender side
    always @(negedge clk)
    begin
        key_item_t it;
        if (!s_tvalid || taken)
        begin
            taken = 0;
            if (tx_gap > 0)
            begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                it = pending_items.pop_front();
                s_tdata  <= it.kb;
                s_tuser  <= {it.bv, it.req};
                s_tlast  <= it.last;
                s_tvalid <= 1'b1;
                tx_gap = burst ? 0 : $urandom_range(0, 3);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // input transfers feed the predictor
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            fold_item(mk(s_tuser[1:0], s_tdata, s_tuser[2], s_tlast));
            items_taken++;
            taken = 1;
        end
    end

    // receiver side with one long hold-off
    always @(negedge clk)
    begin
        if (stall_go && stall_cnt < LONG_HOLD)
        begin
            stall_cnt++;
            m_tready <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // result checking
    always @(posedge clk)
    begin
        answer_t ans;
        if (rst_n && m_tvalid && m_tready)
        begin
            rx_gap = burst ? 0 : $urandom_range(0, 3);
            if (answers_due.size() == 0)
            begin
                $display("%0t: unexpected result kind %0d data %0h", $time, m_tuser, m_tdata);
                failed = 1;
            end
            else
            begin
                ans = answers_due.pop_front();
                if (m_tuser !== ans.kind)
                begin
                    $display("%0t: done_kind expected %0d actual %0d", $time, ans.kind, m_tuser);
                    failed = 1;
                end
                if (m_tdata !== {7'd0, ans.hit})
                begin
                    $display("%0t: answer expected %0h actual %0h", $time,
                             {7'd0, ans.hit}, m_tdata);
                    failed = 1;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < 16; i++)
        begin
            key_pool[i] = {$urandom, $urandom};
            key_len[i]  = $urandom_range(0, 8);
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty key, sign extremes, unknown request, clear
        push(mk(bfdh_pkg::REQ_QUERY, 8'h00, 1'b0, 1'b1));
        push(mk(bfdh_pkg::REQ_INSERT, 8'hFF, 1'b0, 1'b1));
        push(mk(bfdh_pkg::REQ_QUERY, 8'h00, 1'b0, 1'b1));
        push(mk(bfdh_pkg::REQ_INSERT, 8'h00, 1'b1, 1'b1));
        push(mk(bfdh_pkg::REQ_CLEAR, 8'hFF, 1'b1, 1'b0));
        push(mk(bfdh_pkg::REQ_INSERT, 8'h80, 1'b1, 1'b1));
        push(mk(bfdh_pkg::REQ_QUERY, 8'h7F, 1'b1, 1'b0));
        push(mk(REQ_NONE, 8'h55, 1'b0, 1'b0));
        push(mk(bfdh_pkg::REQ_INSERT, 8'hFF, 1'b1, 1'b1));
        push(mk(bfdh_pkg::REQ_QUERY, 8'h80, 1'b1, 1'b1));
        push(mk(bfdh_pkg::REQ_QUERY, 8'h7F, 1'b1, 1'b0));
        push(mk(bfdh_pkg::REQ_QUERY, 8'hFF, 1'b1, 1'b1));
        push(mk(bfdh_pkg::REQ_QUERY, 8'h11, 1'b1, 1'b0));
        push(mk(REQ_NONE, 8'h22, 1'b1, 1'b1));
        push(mk(bfdh_pkg::REQ_QUERY, 8'h00, 1'b1, 1'b1));
        push(mk(bfdh_pkg::REQ_CLEAR, 8'h00, 1'b0, 1'b1));
        push(mk(bfdh_pkg::REQ_QUERY, 8'h80, 1'b1, 1'b1));
        push(mk(bfdh_pkg::REQ_QUERY, 8'hAA, 1'b1, 1'b1));
        drain();

        // register settings, extremes included
        write_reg(bfdh_pkg::CFG_FILTER_SIZE, 17'd8);
        write_reg(bfdh_pkg::CFG_NUM_HASHES, 17'd1);
        burst = 1;
        random_phase(200);
        burst = 0;
        write_reg(bfdh_pkg::CFG_FILTER_SIZE, 17'h1FFFF);
        write_reg(bfdh_pkg::CFG_NUM_HASHES, 17'd16);
        stall_go = 1;
        random_phase(200);
        write_reg(bfdh_pkg::CFG_FILTER_SIZE, 17'd0);
        write_reg(bfdh_pkg::CFG_NUM_HASHES, 17'h1FFFF);
        random_phase(200);
        write_reg(bfdh_pkg::CFG_FILTER_SIZE, 17'd100);
        write_reg(bfdh_pkg::CFG_NUM_HASHES, 17'd0);
        write_reg(CFG_UNUSED, 17'h1FFFF);
        random_phase(200);
        write_reg(bfdh_pkg::CFG_FILTER_SIZE, 17'd65535);
        write_reg(bfdh_pkg::CFG_NUM_HASHES, 17'd3);
        random_phase(200);
        while (items_pushed < ITEM_GOAL)
        begin
            write_reg(bfdh_pkg::CFG_FILTER_SIZE, 17'($urandom_range(8, 65536)));
            write_reg(bfdh_pkg::CFG_NUM_HASHES, 17'($urandom_range(1, 16)));
            burst = $urandom_range(0, 1);
            random_phase(150);
        end

        if (!failed)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
